// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// pre holds, so post holds on the same edge
`define ASSERT_SAME_CYCLE(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");
// pre holds, so post holds on the following edge
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst_n, pre, post)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

    // width of the per-phase delay counter
    localparam int DELAY_WIDTH = 16;
    localparam int CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 16'd500;

    // apb address: one register at byte offset 0, 32-bit data bus, low 16 bits used
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam logic REG_DELAY_CYCLES = 1'b0;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // bus phase index within a command sequence
    typedef enum logic [2:0] {
        PHASE_0 = 3'd0,
        PHASE_1 = 3'd1,
        PHASE_2 = 3'd2,
        PHASE_3 = 3'd3,
        PHASE_4 = 3'd4,
        PHASE_5 = 3'd5,
        PHASE_6 = 3'd6
    } phase_t;

    typedef struct packed {
        logic       cmd_valid;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } res_t;

endpackage

// ===== rtl/core/i2cm_cfg.sv =====
module i2cm_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cm_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [i2cm_pkg::PDATA_WIDTH-1:0]   pwdata,
    output logic [i2cm_pkg::PDATA_WIDTH-1:0]   prdata,
    output logic                               pready,
    output logic [i2cm_pkg::CFG_WIDTH-1:0]     delay_cycles
);
    import i2cm_pkg::*;

    logic [CFG_WIDTH-1:0] delay_reg;
    logic [CFG_WIDTH-1:0] delay_next;
    logic                 hit;

    // register select from the word address
    assign hit = (paddr[PADDR_WIDTH-1:2] == REG_DELAY_CYCLES);

    // write on the access cycle
    always_comb
    begin
        delay_next = delay_reg;
        if (psel && penable && pwrite && hit)
        begin
            delay_next = pwdata[CFG_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else
        begin
            delay_reg <= delay_next;
        end
    end

    // read back, zero-extended
    assign prdata       = hit ? PDATA_WIDTH'(delay_reg) : '0;
    assign pready       = 1'b1;
    assign delay_cycles = delay_reg;

endmodule

// ===== rtl/core/i2cm_seq.sv =====
`include "assert_macros.svh"

module i2cm_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  i2cm_pkg::item_t                 item,
    input  logic [i2cm_pkg::CFG_WIDTH-1:0]  delay_cycles,
    output i2cm_pkg::res_t                  res_next
);
    import i2cm_pkg::*;

    cmd_t                   cmd_reg, cmd_next;
    phase_t                 phase_reg, phase_next;
    logic [3:0]             bit_count_reg, bit_count_next;
    logic [7:0]             shift_reg, shift_next;
    logic [DELAY_WIDTH-1:0] delay_count_reg, delay_count_next;
    logic                   busy_reg, busy_next;
    logic                   nack_reg, nack_next;
    logic                   scl_reg, scl_next;
    logic                   pull_reg, pull_next;
    logic                   ack_choice_reg, ack_choice_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   finish;
    logic [DELAY_WIDTH-1:0] delay_trunc;
    logic [DELAY_WIDTH-1:0] delay_load;

    // phase length, zero acts as one
    assign delay_trunc = DELAY_WIDTH'(delay_cycles);
    assign delay_load  = (delay_trunc == '0) ? DELAY_WIDTH'(1) : delay_trunc;

    // next state for one tick
    always_comb
    begin
        cmd_next         = cmd_reg;
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        busy_next        = busy_reg;
        nack_next        = nack_reg;
        scl_next         = scl_reg;
        pull_next        = pull_reg;
        ack_choice_next  = ack_choice_reg;
        rx_next          = rx_reg;
        finish           = 1'b0;
        if (step)
        begin
            if (busy_reg)
            begin
                if (delay_count_reg > DELAY_WIDTH'(1))
                begin
                    delay_count_next = delay_count_reg - DELAY_WIDTH'(1);
                end
                else
                begin
                    // end of phase: drive the next phase and reload the delay, or finish the command
                    delay_count_next = delay_load;
                    case (cmd_reg)
                        CMD_START:
                        begin
                            case (phase_reg)
                                PHASE_0:
                                begin
                                    pull_next  = 1'b1;
                                    phase_next = PHASE_1;
                                end
                                PHASE_1:
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PHASE_2;
                                end
                                default: finish = 1'b1;
                            endcase
                        end
                        CMD_STOP:
                        begin
                            case (phase_reg)
                                PHASE_0:
                                begin
                                    pull_next  = 1'b0;
                                    phase_next = PHASE_1;
                                end
                                default: finish = 1'b1;
                            endcase
                        end
                        CMD_WRITE:
                        begin
                            case (phase_reg)
                                PHASE_0:
                                begin
                                    scl_next   = 1'b1;
                                    phase_next = PHASE_1;
                                end
                                PHASE_1:
                                begin
                                    scl_next       = 1'b0;
                                    shift_next     = {shift_reg[6:0], 1'b0};
                                    bit_count_next = bit_count_reg + 4'd1;
                                    if (bit_count_next < BITS_PER_BYTE)
                                    begin
                                        pull_next  = ~shift_next[7];
                                        phase_next = PHASE_0;
                                    end
                                    else
                                    begin
                                        // release sda for the slave ack
                                        pull_next  = 1'b0;
                                        phase_next = PHASE_2;
                                    end
                                end
                                PHASE_2:
                                begin
                                    scl_next   = 1'b1;
                                    phase_next = PHASE_3;
                                end
                                PHASE_3:
                                begin
                                    if (!item.sda_in)
                                    begin
                                        scl_next   = 1'b0;
                                        phase_next = PHASE_4;
                                    end
                                    else
                                    begin
                                        // no ack: flag it and go into a stop
                                        nack_next  = 1'b1;
                                        pull_next  = 1'b1;
                                        scl_next   = 1'b1;
                                        phase_next = PHASE_5;
                                    end
                                end
                                PHASE_5:
                                begin
                                    pull_next  = 1'b0;
                                    phase_next = PHASE_6;
                                end
                                default: finish = 1'b1;
                            endcase
                        end
                        default:
                        begin
                            case (phase_reg)
                                PHASE_0:
                                begin
                                    // sample while scl is high
                                    shift_next = {shift_reg[6:0], item.sda_in};
                                    scl_next   = 1'b0;
                                    phase_next = PHASE_1;
                                end
                                PHASE_1:
                                begin
                                    bit_count_next = bit_count_reg + 4'd1;
                                    if (bit_count_next < BITS_PER_BYTE)
                                    begin
                                        scl_next   = 1'b1;
                                        phase_next = PHASE_0;
                                    end
                                    else
                                    begin
                                        pull_next  = ack_choice_reg;
                                        phase_next = PHASE_2;
                                    end
                                end
                                PHASE_2:
                                begin
                                    scl_next   = 1'b1;
                                    phase_next = PHASE_3;
                                end
                                PHASE_3:
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PHASE_4;
                                end
                                PHASE_4:
                                begin
                                    if (ack_choice_reg)
                                    begin
                                        pull_next  = 1'b0;
                                        phase_next = PHASE_5;
                                    end
                                    else
                                    begin
                                        rx_next = shift_reg;
                                        finish  = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    rx_next = shift_reg;
                                    finish  = 1'b1;
                                end
                            endcase
                        end
                    endcase
                    if (finish)
                    begin
                        busy_next        = 1'b0;
                        phase_next       = PHASE_0;
                        delay_count_next = '0;
                    end
                end
            end
            else if (item.cmd_valid)
            begin
                // take a new command and drive its first phase
                cmd_next         = item.cmd;
                bit_count_next   = '0;
                busy_next        = 1'b1;
                phase_next       = PHASE_0;
                delay_count_next = delay_load;
                case (item.cmd)
                    CMD_START:
                    begin
                        scl_next  = 1'b1;
                        pull_next = 1'b0;
                    end
                    CMD_STOP:
                    begin
                        scl_next  = 1'b1;
                        pull_next = 1'b1;
                    end
                    CMD_WRITE:
                    begin
                        shift_next = item.tx_byte;
                        nack_next  = 1'b0;
                        pull_next  = ~item.tx_byte[7];
                    end
                    default:
                    begin
                        ack_choice_next = item.send_ack;
                        shift_next      = '0;
                        scl_next        = 1'b1;
                        pull_next       = 1'b0;
                    end
                endcase
            end
        end
    end

    // result of this tick
    always_comb
    begin
        res_next.scl_level    = scl_next;
        res_next.sda_pull_low = pull_next;
        res_next.busy         = busy_next;
        res_next.done         = finish;
        res_next.rx_byte      = rx_next;
        res_next.ack_missing  = nack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg         <= CMD_START;
            phase_reg       <= PHASE_0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            delay_count_reg <= '0;
            busy_reg        <= 1'b0;
            nack_reg        <= 1'b0;
            scl_reg         <= 1'b1;
            pull_reg        <= 1'b0;
            ack_choice_reg  <= 1'b0;
            rx_reg          <= '0;
        end
        else
        begin
            cmd_reg         <= cmd_next;
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            delay_count_reg <= delay_count_next;
            busy_reg        <= busy_next;
            nack_reg        <= nack_next;
            scl_reg         <= scl_next;
            pull_reg        <= pull_next;
            ack_choice_reg  <= ack_choice_next;
            rx_reg          <= rx_next;
        end
    end

    // a running command always has a phase delay loaded
    `ASSERT_SAME_CYCLE(a_busy_delay, clk, rst_n, busy_reg, delay_count_reg != '0)
    // idle sits at the first phase
    `ASSERT_SAME_CYCLE(a_idle_phase, clk, rst_n, !busy_reg, phase_reg == PHASE_0)
    // a command offered while idle starts a sequence
    `ASSERT_NEXT_CYCLE(a_take_cmd, clk, rst_n, step && !busy_reg && item.cmd_valid, busy_reg)
    // completion drops busy
    `ASSERT_NEXT_CYCLE(a_done_idle, clk, rst_n, step && res_next.done, !busy_reg)

endmodule

// ===== rtl/core/i2c_master_byte_engine.sv =====
// i2c master byte engine
// each item on the input channel is one tick of the bus sequencer. it carries
// an optional command (cmd_valid, cmd, tx_byte, send_ack) and the sampled sda
// level. each item yields exactly one result item: scl_level, sda_pull_low,
// busy_res, done_res, rx_byte and ack_missing.
// a command is taken only on a tick while idle; it then runs as a series of
// bus phases of delay_cycles ticks each (apb register at offset 0, reset 500).
// an accepted item sits in the input register; the sequencer update loads its
// result into the result register when that register is empty or being taken.
// throughput: one item per cycle while out_ready is high (combinational update).
// when out_ready is low the result register holds and one more item is taken
// into the input register; after that in_ready stays low until the result is
// taken.
// reset: sequencer idle (scl high, sda released, no command running, rx_byte and
// ack_missing zero), delay_cycles 500, both channels empty, result data not reset.
module i2c_master_byte_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd_valid,
    input  logic [1:0]                        cmd,
    input  logic [7:0]                        tx_byte,
    input  logic                              send_ack,
    input  logic                              sda_in,
    // result item channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              scl_level,
    output logic                              sda_pull_low,
    output logic                              busy_res,
    output logic                              done_res,
    output logic [7:0]                        rx_byte,
    output logic                              ack_missing,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cm_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [i2cm_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [i2cm_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                              pready
);
    import i2cm_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    item_t                item_reg, item_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 res_reg, res_next_q;
    res_t                 res_next;
    logic                 step;
    logic [CFG_WIDTH-1:0] delay_cycles;

    // the held item is processed when the result register is free
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg && !step;
        item_next     = item_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next       = 1'b1;
            item_next.cmd_valid = cmd_valid;
            item_next.cmd       = cmd_t'(cmd);
            item_next.tx_byte   = tx_byte;
            item_next.send_ack  = send_ack;
            item_next.sda_in    = sda_in;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        res_next_q     = res_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            res_next_q     = res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next_q;
    end

    i2cm_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .delay_cycles (delay_cycles)
    );

    i2cm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (item_reg),
        .delay_cycles (delay_cycles),
        .res_next     (res_next)
    );

    // result ports
    assign out_valid    = out_valid_reg;
    assign scl_level    = res_reg.scl_level;
    assign sda_pull_low = res_reg.sda_pull_low;
    assign busy_res     = res_reg.busy;
    assign done_res     = res_reg.done;
    assign rx_byte      = res_reg.rx_byte;
    assign ack_missing  = res_reg.ack_missing;

endmodule

// ===== test/i2c_master_byte_engine_test.sv =====
module i2c_master_byte_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam logic [PADDR_WIDTH-1:0] DELAY_ADDR = PADDR_WIDTH'(4 * int'(REG_DELAY_CYCLES));

    // sequencer state as the bus engine holds it
    typedef struct packed {
        cmd_t                   op;
        phase_t                 phase;
        logic [3:0]             nbits;
        logic [7:0]             shreg;
        logic [DELAY_WIDTH-1:0] hold_cnt;
        logic                   running;
        logic                   nack;
        logic                   scl;
        logic                   pull;
        logic                   ack_sel;
        logic [7:0]             rx_last;
        logic [CFG_WIDTH-1:0]   delay_cfg;
    } engine_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd_valid = 1'b0;
    logic [1:0] cmd = 2'd0;
    logic [7:0] tx_byte = 8'd0;
    logic send_ack = 1'b0;
    logic sda_in = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic scl_level;
    logic sda_pull_low;
    logic busy_res;
    logic done_res;
    logic [7:0] rx_byte;
    logic ack_missing;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr = '0;
    logic [PDATA_WIDTH-1:0] pwdata = '0;
    logic [PDATA_WIDTH-1:0] prdata;
    logic pready;

    // seq_state follows accepted items, seq_plan runs ahead while items are queued
    engine_t seq_state;
    engine_t seq_plan;
    item_t bus_ticks_queued[$];
    res_t line_states_due[$];
    int ticks_planned = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit mismatch_seen = 1'b0;

    i2c_master_byte_engine dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd_valid(cmd_valid),
        .cmd(cmd),
        .tx_byte(tx_byte),
        .send_ack(send_ack),
        .sda_in(sda_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .scl_level(scl_level),
        .sda_pull_low(sda_pull_low),
        .busy_res(busy_res),
        .done_res(done_res),
        .rx_byte(rx_byte),
        .ack_missing(ack_missing),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    // lines idle high, delay at its reset value
    function automatic engine_t idle_engine();
        engine_t s;
        s = '0;
        s.scl = 1'b1;
        s.delay_cfg = DELAY_RESET;
        return s;
    endfunction

    // start a bus phase; a zero delay still holds for one tick
    function automatic void enter_phase(inout engine_t s, input phase_t p);
        logic [DELAY_WIDTH-1:0] len;
        len = DELAY_WIDTH'(s.delay_cfg);
        s.phase = p;
        s.hold_cnt = (len == '0) ? DELAY_WIDTH'(1) : len;
    endfunction

    // end of the current phase, returns 1 when the command is complete
    function automatic bit finish_phase(inout engine_t s, input logic sda);
        bit fin;
        fin = 1'b0;
        case (s.op)
            CMD_START:
                case (s.phase)
                    PHASE_0: begin s.pull = 1'b1; enter_phase(s, PHASE_1); end
                    PHASE_1: begin s.scl = 1'b0; enter_phase(s, PHASE_2); end
                    default: fin = 1'b1;
                endcase
            CMD_STOP:
                if (s.phase == PHASE_0)
                begin
                    s.pull = 1'b0;
                    enter_phase(s, PHASE_1);
                end
                else
                    fin = 1'b1;
            CMD_WRITE:
                case (s.phase)
                    PHASE_0: begin s.scl = 1'b1; enter_phase(s, PHASE_1); end
                    PHASE_1:
                    begin
                        s.scl = 1'b0;
                        s.shreg = s.shreg << 1;
                        s.nbits = s.nbits + 4'd1;
                        if (s.nbits < BITS_PER_BYTE)
                        begin
                            s.pull = ~s.shreg[7];
                            enter_phase(s, PHASE_0);
                        end
                        else
                        begin
                            s.pull = 1'b0;
                            enter_phase(s, PHASE_2);
                        end
                    end
                    PHASE_2: begin s.scl = 1'b1; enter_phase(s, PHASE_3); end
                    PHASE_3:
                        // no acknowledge: pull sda low with scl high, then release it
                        if (!sda)
                        begin
                            s.scl = 1'b0;
                            enter_phase(s, PHASE_4);
                        end
                        else
                        begin
                            s.nack = 1'b1;
                            s.pull = 1'b1;
                            s.scl = 1'b1;
                            enter_phase(s, PHASE_5);
                        end
                    PHASE_5: begin s.pull = 1'b0; enter_phase(s, PHASE_6); end
                    default: fin = 1'b1;
                endcase
            default:
                case (s.phase)
                    PHASE_0:
                    begin
                        s.shreg = {s.shreg[6:0], sda};
                        s.scl = 1'b0;
                        enter_phase(s, PHASE_1);
                    end
                    PHASE_1:
                    begin
                        s.nbits = s.nbits + 4'd1;
                        if (s.nbits < BITS_PER_BYTE)
                        begin
                            s.scl = 1'b1;
                            enter_phase(s, PHASE_0);
                        end
                        else
                        begin
                            s.pull = s.ack_sel;
                            enter_phase(s, PHASE_2);
                        end
                    end
                    PHASE_2: begin s.scl = 1'b1; enter_phase(s, PHASE_3); end
                    PHASE_3: begin s.scl = 1'b0; enter_phase(s, PHASE_4); end
                    default:
                        if (s.phase == PHASE_4 && s.ack_sel)
                        begin
                            s.pull = 1'b0;
                            enter_phase(s, PHASE_5);
                        end
                        else
                        begin
                            s.rx_last = s.shreg;
                            fin = 1'b1;
                        end
                endcase
        endcase
        return fin;
    endfunction

    // one sequencer tick: advance a running command or take a new one when idle
    function automatic void bus_tick(inout engine_t s, input item_t t, output res_t r);
        logic done;
        done = 1'b0;
        if (s.running)
        begin
            if (s.hold_cnt > DELAY_WIDTH'(1))
                s.hold_cnt = s.hold_cnt - DELAY_WIDTH'(1);
            else if (finish_phase(s, t.sda_in))
            begin
                s.running = 1'b0;
                s.phase = PHASE_0;
                s.hold_cnt = '0;
                done = 1'b1;
            end
        end
        else if (t.cmd_valid)
        begin
            s.op = t.cmd;
            s.nbits = '0;
            s.running = 1'b1;
            case (t.cmd)
                CMD_START: begin s.scl = 1'b1; s.pull = 1'b0; end
                CMD_STOP: begin s.pull = 1'b1; s.scl = 1'b1; end
                CMD_WRITE:
                begin
                    s.shreg = t.tx_byte;
                    s.nack = 1'b0;
                    s.pull = ~t.tx_byte[7];
                end
                default:
                begin
                    s.ack_sel = t.send_ack;
                    s.shreg = '0;
                    s.pull = 1'b0;
                    s.scl = 1'b1;
                end
            endcase
            enter_phase(s, PHASE_0);
        end
        r.scl_level = s.scl;
        r.sda_pull_low = s.pull;
        r.busy = s.running;
        r.done = done;
        r.rx_byte = s.rx_last;
        r.ack_missing = s.nack;
    endfunction

    // item with random content, sda low with the given odds
    function automatic item_t random_tick(input logic take, input int zero_pct);
        item_t t;
        t.cmd_valid = take;
        t.cmd = cmd_t'($urandom_range(0, 3));
        t.tx_byte = 8'($urandom);
        t.send_ack = 1'($urandom);
        t.sda_in = ($urandom_range(0, 99) >= zero_pct);
        return t;
    endfunction

    task automatic push_tick(input item_t t);
        res_t ignored;
        bus_tick(seq_plan, t, ignored);
        bus_ticks_queued.push_back(t);
        ticks_planned++;
    endtask

    // one command, then ticks until it completes, some with a command that gets ignored
    task automatic issue(input cmd_t op, input logic [7:0] tx, input logic ack,
                         input int zero_pct);
        item_t t;
        t = random_tick(1'b1, zero_pct);
        t.cmd = op;
        t.tx_byte = tx;
        t.send_ack = ack;
        push_tick(t);
        while (seq_plan.running)
            push_tick(random_tick($urandom_range(0, 9) == 0, zero_pct));
    endtask

    // mostly start, bytes, stop; some lone commands and missing stops
    task automatic run_random(input int budget);
        int stop_at;
        int n;
        stop_at = ticks_planned + budget;
        while (ticks_planned < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                issue(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 50);
            else
            begin
                issue(CMD_START, 8'($urandom), 1'($urandom), 50);
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    if ($urandom_range(0, 1))
                        issue(CMD_WRITE, 8'($urandom), 1'($urandom),
                              ($urandom_range(0, 4) == 0) ? 10 : 95);
                    else
                        issue(CMD_READ, 8'($urandom), 1'($urandom), 50);
                end
                if ($urandom_range(0, 9) != 0)
                    issue(CMD_STOP, 8'($urandom), 1'($urandom), 50);
            end
            repeat ($urandom_range(0, 3))
                push_tick(random_tick(1'b0, 50));
        end
    endtask

    // wait until every queued item is taken and every result has come back
    task automatic drain();
        while (!(bus_ticks_queued.size() == 0 && !in_valid && line_states_due.size() == 0))
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_WIDTH-1:0] wdata,
                              output logic [PDATA_WIDTH-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= DELAY_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // write the phase length with junk in the upper bits, read it back
    task automatic program_delay(input logic [CFG_WIDTH-1:0] value);
        logic [PDATA_WIDTH-1:0] wdata;
        logic [PDATA_WIDTH-1:0] back;
        drain();
        wdata = $urandom;
        wdata[CFG_WIDTH-1:0] = value;
        apb_access(1'b1, wdata, back);
        apb_access(1'b0, '0, back);
        if (back[CFG_WIDTH-1:0] !== value)
        begin
            $error("delay_cycles expected %0d got %0d", value, back[CFG_WIDTH-1:0]);
            mismatch_seen = 1'b1;
        end
        seq_plan.delay_cfg = value;
        seq_state.delay_cfg = value;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    // input side: predict on acceptance, then present the next queued item
    always @(posedge clk or negedge rst_n)
    begin : drive_ticks
        item_t seen;
        item_t nxt;
        res_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd_valid <= 1'b0;
            cmd <= 2'd0;
            tx_byte <= 8'd0;
            send_ack <= 1'b0;
            sda_in <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen.cmd_valid = cmd_valid;
                seen.cmd = cmd_t'(cmd);
                seen.tx_byte = tx_byte;
                seen.send_ack = send_ack;
                seen.sda_in = sda_in;
                bus_tick(seq_state, seen, r);
                line_states_due.push_back(r);
            end
            if (!in_valid || in_ready)
            begin
                if (bus_ticks_queued.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = bus_ticks_queued.pop_front();
                    in_valid <= 1'b1;
                    cmd_valid <= nxt.cmd_valid;
                    cmd <= nxt.cmd;
                    tx_byte <= nxt.tx_byte;
                    send_ack <= nxt.send_ack;
                    sda_in <= nxt.sda_in;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side: check each result item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_lines
        res_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (line_states_due.size() == 0)
                begin
                    $error("result item with nothing expected");
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = line_states_due.pop_front();
                    compare_field("scl_level", 8'(want.scl_level), 8'(scl_level));
                    compare_field("sda_pull_low", 8'(want.sda_pull_low), 8'(sda_pull_low));
                    compare_field("busy_res", 8'(want.busy), 8'(busy_res));
                    compare_field("done_res", 8'(want.done), 8'(done_res));
                    compare_field("rx_byte", want.rx_byte, rx_byte);
                    compare_field("ack_missing", 8'(want.ack_missing), 8'(ack_missing));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [PDATA_WIDTH-1:0] back;
        seq_state = idle_engine();
        seq_plan = idle_engine();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver stalls often
        send_idle_pct = 27;
        recv_idle_pct = 83;
        apb_access(1'b0, '0, back);
        if (back[CFG_WIDTH-1:0] !== DELAY_RESET)
        begin
            $error("delay_cycles expected %0d got %0d", DELAY_RESET, back[CFG_WIDTH-1:0]);
            mismatch_seen = 1'b1;
        end

        // directed: every command, byte extremes, ack and nack both ways
        program_delay(16'd1);
        issue(CMD_STOP, 8'($urandom), 1'b0, 50);
        issue(CMD_START, 8'($urandom), 1'b0, 50);
        issue(CMD_WRITE, 8'hFF, 1'b0, 100);
        issue(CMD_WRITE, 8'h00, 1'b1, 100);
        issue(CMD_WRITE, 8'h80, 1'b0, 0);
        issue(CMD_START, 8'($urandom), 1'b1, 50);
        issue(CMD_WRITE, 8'h01, 1'b0, 100);
        issue(CMD_READ, 8'($urandom), 1'b1, 0);
        issue(CMD_READ, 8'($urandom), 1'b0, 100);
        issue(CMD_READ, 8'($urandom), 1'b1, 50);
        issue(CMD_START, 8'($urandom), 1'b0, 50);
        issue(CMD_WRITE, 8'h5A, 1'b0, 100);
        issue(CMD_WRITE, 8'hA5, 1'b1, 0);
        issue(CMD_READ, 8'($urandom), 1'b0, 50);
        issue(CMD_STOP, 8'($urandom), 1'b1, 50);
        issue(CMD_STOP, 8'($urandom), 1'b0, 50);

        // zero phase length behaves as one
        program_delay(16'd0);
        run_random(250);
        program_delay(16'd3);
        run_random(300);

        // swap the stall odds
        program_delay(16'd2);
        send_idle_pct = 83;
        recv_idle_pct = 27;
        run_random(300);
        program_delay(16'd5);
        run_random(300);

        // full rate, the widest phase length read back, then a slow stop
        program_delay(16'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(300);
        program_delay(16'hFFFF);
        program_delay(16'd20);
        issue(CMD_STOP, 8'($urandom), 1'($urandom), 50);

        drain();
        repeat (8) @(posedge clk);
        if (!mismatch_seen)
            $display("i2c_master_byte_engine: match");
        else
            $display("i2c_master_byte_engine: mismatch");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("i2c_master_byte_engine: mismatch");
        $finish;
    end

endmodule
